// ===== design/rrs_pkg.sv =====
`default_nettype none

package rrs_pkg;

	localparam int MAX_PROCESSES = 32;
	localparam int ID_W          = $clog2(MAX_PROCESSES);
	localparam int CNT_W         = $clog2(MAX_PROCESSES + 1);
	localparam int BURST_W       = 16;
	localparam int CLK_W         = 21;
	localparam int PDATA_W       = 32;
	localparam int PADDR_W       = 3;
	localparam int REG_IDX_W     = PADDR_W - 2;

	localparam logic [CLK_W-1:0]     CLOCK_MAX        = '1;
	localparam logic [BURST_W-1:0]   TIME_SLICE_RESET = 16'd1;

	// input command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_TIME_SLICE = '0;

	typedef struct packed {
		logic load;
		logic q_rd;
		logic b_rd;
		logic commit;
		logic emit_empty;
	} dp_cmd_t;

	typedef struct packed {
		logic queue_empty;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== design/rrs_in_if.sv =====
`default_nettype none

interface rrs_in_if;
	logic                        valid;
	logic                        ready;
	logic                        command;
	logic [rrs_pkg::BURST_W-1:0] burst_time;

	modport source (output valid, output command, output burst_time, input ready);
	modport sink   (input valid, input command, input burst_time, output ready);
endinterface

`default_nettype wire

// ===== design/rrs_out_if.sv =====
`default_nettype none

interface rrs_out_if;
	logic                        valid;
	logic                        ready;
	logic [rrs_pkg::ID_W-1:0]    process_id;
	logic [rrs_pkg::BURST_W-1:0] run_time;
	logic [rrs_pkg::CLK_W-1:0]   clock_res;
	logic                        finished;
	logic [rrs_pkg::CLK_W-1:0]   turnaround;
	logic [rrs_pkg::CLK_W-1:0]   waiting;
	logic                        queue_empty;

	modport source (output valid, output process_id, output run_time, output clock_res,
		output finished, output turnaround, output waiting, output queue_empty,
		input ready);
	modport sink   (input valid, input process_id, input run_time, input clock_res,
		input finished, input turnaround, input waiting, input queue_empty,
		output ready);
endinterface

`default_nettype wire

// ===== design/rrs_ctrl.sv =====
`default_nettype none

module rrs_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_command,
	output logic                   in_ready,
	input  wire rrs_pkg::dp_stat_t stat,
	output rrs_pkg::dp_cmd_t       ctl
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READQ,
		ST_READB,
		ST_EMPTY
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   accept;

	assign accept = in_valid && in_ready;

	always_comb begin
		ctl       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_command == rrs_pkg::CMD_LOAD) begin
						ctl.load = 1'b1;
					end else if (stat.queue_empty) begin
						state_nxt = ST_EMPTY;
					end else begin
						ctl.q_rd  = 1'b1;
						state_nxt = ST_READQ;
					end
				end
			end
			ST_READQ: begin
				ctl.b_rd  = 1'b1;
				state_nxt = ST_READB;
			end
			ST_READB: begin
				if (stat.out_free) begin
					ctl.commit = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			ST_EMPTY: begin
				if (stat.out_free) begin
					ctl.emit_empty = 1'b1;
					state_nxt      = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			in_ready <= 1'b1;
		end else begin
			state_q  <= state_nxt;
			in_ready <= (state_nxt == ST_IDLE);
		end
	end

endmodule

`default_nettype wire

// ===== design/rrs_datapath.sv =====
`default_nettype none

module rrs_datapath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire rrs_pkg::dp_cmd_t            ctl,
	output rrs_pkg::dp_stat_t                stat,
	input  wire logic [rrs_pkg::BURST_W-1:0] burst_time,
	input  wire logic                        cfg_we,
	input  wire logic [rrs_pkg::BURST_W-1:0] cfg_wdata,
	output logic [rrs_pkg::BURST_W-1:0]      time_slice,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [rrs_pkg::ID_W-1:0]         process_id,
	output logic [rrs_pkg::BURST_W-1:0]      run_time,
	output logic [rrs_pkg::CLK_W-1:0]        clock_res,
	output logic                             finished,
	output logic [rrs_pkg::CLK_W-1:0]        turnaround,
	output logic [rrs_pkg::CLK_W-1:0]        waiting,
	output logic                             queue_empty
);

	localparam int ID_W  = rrs_pkg::ID_W;
	localparam int CNT_W = rrs_pkg::CNT_W;
	localparam int BW    = rrs_pkg::BURST_W;
	localparam int CW    = rrs_pkg::CLK_W;
	localparam int MAXP  = rrs_pkg::MAX_PROCESSES;

	// memories
	logic [ID_W-1:0] queue_mem [MAXP];
	logic [BW-1:0]   rem_mem   [MAXP];
	logic [BW-1:0]   orig_mem  [MAXP];

	// control state
	logic [BW-1:0]    time_slice_q;
	logic [ID_W-1:0]  head_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] loaded_q;
	logic [CW-1:0]    clock_q;
	logic             out_valid_q;

	// read data
	logic [ID_W-1:0] qrd_q;
	logic [BW-1:0]   rem_rd_q;
	logic [BW-1:0]   orig_rd_q;

	// result register
	logic [ID_W-1:0] process_id_q;
	logic [BW-1:0]   run_time_q;
	logic [CW-1:0]   clock_res_q;
	logic            finished_q;
	logic [CW-1:0]   turnaround_q;
	logic [CW-1:0]   waiting_q;
	logic            queue_empty_q;

	logic [CNT_W-1:0] tail_sum;
	logic [ID_W-1:0]  tail;
	logic [ID_W-1:0]  head_nxt;
	logic [ID_W-1:0]  load_id;
	logic             load_ok;
	logic             rem_gt;
	logic             fin;
	logic [BW-1:0]    run;
	logic [BW-1:0]    rem_new;
	logic [CW:0]      clk_sum;
	logic [CW-1:0]    clk_new;
	logic [CW-1:0]    wait_new;
	logic             q_we;
	logic             rem_we;
	logic [ID_W-1:0]  q_wdata;
	logic [ID_W-1:0]  rem_waddr;
	logic [BW-1:0]    rem_wdata;

	assign tail_sum = CNT_W'(head_q) + count_q;
	assign tail     = (tail_sum >= CNT_W'(MAXP)) ? ID_W'(tail_sum - CNT_W'(MAXP))
		: tail_sum[ID_W-1:0];
	assign head_nxt = (head_q == ID_W'(MAXP - 1)) ? '0 : head_q + 1'b1;
	assign load_id  = loaded_q[ID_W-1:0];
	assign load_ok  = ctl.load && (loaded_q != CNT_W'(MAXP));

	// slice arithmetic
	assign rem_gt   = rem_rd_q > time_slice_q;
	assign fin      = !rem_gt;
	assign run      = rem_gt ? time_slice_q : rem_rd_q;
	assign rem_new  = rem_gt ? rem_rd_q - time_slice_q : '0;
	assign clk_sum  = {1'b0, clock_q} + (CW + 1)'(run);
	assign clk_new  = clk_sum[CW] ? rrs_pkg::CLOCK_MAX : clk_sum[CW-1:0];
	assign wait_new = clk_new - CW'(orig_rd_q);

	assign q_we      = load_ok || (ctl.commit && !fin);
	assign q_wdata   = ctl.load ? load_id : qrd_q;
	assign rem_we    = load_ok || ctl.commit;
	assign rem_waddr = ctl.load ? load_id : qrd_q;
	assign rem_wdata = ctl.load ? burst_time : rem_new;

	always_ff @(posedge clk) begin
		if (q_we) begin
			queue_mem[tail] <= q_wdata;
		end
		if (rem_we) begin
			rem_mem[rem_waddr] <= rem_wdata;
		end
		if (load_ok) begin
			orig_mem[load_id] <= burst_time;
		end
		if (ctl.q_rd) begin
			qrd_q <= queue_mem[head_q];
		end
		if (ctl.b_rd) begin
			rem_rd_q  <= rem_mem[qrd_q];
			orig_rd_q <= orig_mem[qrd_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_slice_q <= rrs_pkg::TIME_SLICE_RESET;
			head_q       <= '0;
			count_q      <= '0;
			loaded_q     <= '0;
			clock_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				time_slice_q <= cfg_wdata;
			end
			if (load_ok) begin
				loaded_q <= loaded_q + 1'b1;
				count_q  <= count_q + 1'b1;
			end
			if (ctl.commit) begin
				head_q  <= head_nxt;
				clock_q <= clk_new;
				if (fin) begin
					count_q <= count_q - 1'b1;
				end
			end
			if (ctl.commit || ctl.emit_empty) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			process_id_q  <= qrd_q;
			run_time_q    <= run;
			clock_res_q   <= clk_new;
			finished_q    <= fin;
			turnaround_q  <= fin ? clk_new : '0;
			waiting_q     <= fin ? wait_new : '0;
			queue_empty_q <= 1'b0;
		end else if (ctl.emit_empty) begin
			process_id_q  <= '0;
			run_time_q    <= '0;
			clock_res_q   <= '0;
			finished_q    <= 1'b0;
			turnaround_q  <= '0;
			waiting_q     <= '0;
			queue_empty_q <= 1'b1;
		end
	end

	assign stat.queue_empty = (count_q == '0);
	assign stat.out_free    = !out_valid_q || out_ready;

	assign time_slice  = time_slice_q;
	assign out_valid   = out_valid_q;
	assign process_id  = process_id_q;
	assign run_time    = run_time_q;
	assign clock_res   = clock_res_q;
	assign finished    = finished_q;
	assign turnaround  = turnaround_q;
	assign waiting     = waiting_q;
	assign queue_empty = queue_empty_q;

endmodule

`default_nettype wire

// ===== design/round_robin_scheduler.sv =====
// channel  dir  payload                                              handshake
// cmd      in   command, burst_time                                  valid/ready
// report   out  process_id, run_time, clock_res, finished,           valid/ready
//               turnaround, waiting, queue_empty
// apb      in   time_slice at byte address 0                         psel/penable
//
// A load is written in the cycle it is accepted. A step runs as a ready-queue
// read at the head, a burst memory read for that id, then slice arithmetic and
// write-back; a step on an empty queue instead emits an empty result. The
// write-back waits while the result register is still held.
// Reset clears pointers, counts and clock and sets time_slice to 1; the
// memories are not cleared and no entry is read before it is written.
`default_nettype none

module round_robin_scheduler (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [rrs_pkg::PADDR_W-1:0] paddr,
	input  wire logic [rrs_pkg::PDATA_W-1:0] pwdata,
	output logic [rrs_pkg::PDATA_W-1:0]      prdata,
	output logic                             pready,
	rrs_in_if.sink                           cmd,
	rrs_out_if.source                        report
);

	rrs_pkg::dp_cmd_t                ctl;
	rrs_pkg::dp_stat_t               stat;
	logic                            reg_sel;
	logic                            cfg_we;
	logic [rrs_pkg::BURST_W-1:0]     time_slice;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[rrs_pkg::PADDR_W-1:2] == rrs_pkg::REG_TIME_SLICE);
	assign cfg_we  = psel && penable && pwrite && pready && reg_sel;
	assign prdata  = reg_sel ? rrs_pkg::PDATA_W'(time_slice) : '0;

	rrs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (cmd.valid),
		.in_command (cmd.command),
		.in_ready   (cmd.ready),
		.stat       (stat),
		.ctl        (ctl)
	);

	rrs_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.stat        (stat),
		.burst_time  (cmd.burst_time),
		.cfg_we      (cfg_we),
		.cfg_wdata   (pwdata[rrs_pkg::BURST_W-1:0]),
		.time_slice  (time_slice),
		.out_valid   (report.valid),
		.out_ready   (report.ready),
		.process_id  (report.process_id),
		.run_time    (report.run_time),
		.clock_res   (report.clock_res),
		.finished    (report.finished),
		.turnaround  (report.turnaround),
		.waiting     (report.waiting),
		.queue_empty (report.queue_empty)
	);

endmodule

`default_nettype wire

// ===== design/rrs_checker.sv =====
`default_nettype none

module rrs_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        in_command,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [rrs_pkg::ID_W-1:0]    process_id,
	input wire logic [rrs_pkg::BURST_W-1:0] run_time,
	input wire logic [rrs_pkg::CLK_W-1:0]   clock_res,
	input wire logic                        finished,
	input wire logic [rrs_pkg::CLK_W-1:0]   turnaround,
	input wire logic [rrs_pkg::CLK_W-1:0]   waiting,
	input wire logic                        queue_empty
);

	// a step holds off the next transfer
	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_command == rrs_pkg::CMD_STEP) |=> !in_ready)
		else $error("input accepted during step");

	// a new result only follows a busy cycle
	a_result_after_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without a step");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(process_id) && $stable(clock_res))
		else $error("result dropped while stalled");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && queue_empty |-> process_id == '0 && run_time == '0
			&& clock_res == '0 && !finished)
		else $error("empty result carries data");

	a_unfinished_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !finished |-> turnaround == '0 && waiting == '0)
		else $error("turnaround or waiting set on unfinished slice");

endmodule

bind round_robin_scheduler rrs_checker u_rrs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (cmd.valid),
	.in_ready    (cmd.ready),
	.in_command  (cmd.command),
	.out_valid   (report.valid),
	.out_ready   (report.ready),
	.process_id  (report.process_id),
	.run_time    (report.run_time),
	.clock_res   (report.clock_res),
	.finished    (report.finished),
	.turnaround  (report.turnaround),
	.waiting     (report.waiting),
	.queue_empty (report.queue_empty)
);

`default_nettype wire
